@@ design/hhcv_pkg.sv @@
package hhcv_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 24;
	localparam int IDX_W = 2;
	// The slot setting register is two bits wide, so at most three slots report.
	localparam int REPORT_SLOTS = 3;
	localparam logic [IDX_W-1:0] ACTIVE_SLOTS_RESET = 2'd3;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic end_of_set;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] slot_index;
		logic signed [VALUE_W-1:0] candidate_value;
		logic [COUNT_W-1:0] candidate_count;
		logic final_result;
	} out_word_t;

	typedef struct packed {
		logic [REPORT_SLOTS-1:0][VALUE_W-1:0] values;
		logic [REPORT_SLOTS-1:0][COUNT_W-1:0] counts;
		logic [IDX_W-1:0] used;
	} snap_t;

endpackage

@@ design/hhcv_front.sv @@
module hhcv_front #(
	parameter int SLOTS = 3,
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic [hhcv_pkg::IDX_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  hhcv_pkg::in_word_t in_word,
	output logic push_valid,
	input  logic push_ready,
	output hhcv_pkg::snap_t push_data
);

	localparam logic [VALUE_BITS-1:0] VALUE_RESET = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [hhcv_pkg::IDX_W-1:0] active_slots_q;
	logic [VALUE_BITS-1:0] val_q [SLOTS];
	logic [COUNT_BITS-1:0] cnt_q [SLOTS];
	logic [VALUE_BITS-1:0] nval [SLOTS];
	logic [COUNT_BITS-1:0] ncnt [SLOTS];
	logic [SLOTS-1:0] act, mhit, fhit;
	logic done;
	logic [hhcv_pkg::IDX_W-1:0] used;
	logic [VALUE_BITS-1:0] v;
	logic accept;
	logic [hhcv_pkg::VALUE_W-1:0] rep_val [hhcv_pkg::REPORT_SLOTS];
	logic [hhcv_pkg::COUNT_W-1:0] rep_cnt [hhcv_pkg::REPORT_SLOTS];

	assign in_ready = push_ready;
	assign accept = in_valid && in_ready;
	assign v = VALUE_BITS'(in_word.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= hhcv_pkg::ACTIVE_SLOTS_RESET;
		end else if (cfg_wen) begin
			active_slots_q <= cfg_wdata;
		end
	end

	// A zero setting acts as one slot, and the slots in use never exceed the slots built.
	always_comb begin
		used = (active_slots_q == '0) ? hhcv_pkg::IDX_W'(1) : active_slots_q;
		if (int'(used) > SLOTS) begin
			used = hhcv_pkg::IDX_W'(SLOTS);
		end
	end

	always_comb begin
		done = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			act[i] = i < int'(used);
			mhit[i] = 1'b0;
			fhit[i] = 1'b0;
		end
		// An equal value wins first, even in a stale slot whose count is zero.
		for (int i = 0; i < SLOTS; i++) begin
			if (act[i] && val_q[i] == v && !done) begin
				mhit[i] = 1'b1;
				done = 1'b1;
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (act[i] && cnt_q[i] == '0 && !done) begin
				fhit[i] = 1'b1;
				done = 1'b1;
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			nval[i] = val_q[i];
			ncnt[i] = cnt_q[i];
			if (mhit[i]) begin
				if (cnt_q[i] != COUNT_MAX) begin
					ncnt[i] = cnt_q[i] + COUNT_BITS'(1);
				end
			end else if (fhit[i]) begin
				nval[i] = v;
				ncnt[i] = COUNT_BITS'(1);
			end else if (!done && act[i]) begin
				ncnt[i] = cnt_q[i] - COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				val_q[i] <= VALUE_RESET;
				cnt_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < SLOTS; i++) begin
				val_q[i] <= in_word.end_of_set ? VALUE_RESET : nval[i];
				cnt_q[i] <= in_word.end_of_set ? '0 : ncnt[i];
			end
		end
	end

	for (genvar r = 0; r < hhcv_pkg::REPORT_SLOTS; r++) begin : g_rep
		if (r < SLOTS) begin : g_used
			assign rep_val[r] = hhcv_pkg::VALUE_W'(nval[r]);
			assign rep_cnt[r] = hhcv_pkg::COUNT_W'(ncnt[r]);
		end else begin : g_none
			assign rep_val[r] = '0;
			assign rep_cnt[r] = '0;
		end
	end

	always_comb begin
		push_data.used = used;
		for (int r = 0; r < hhcv_pkg::REPORT_SLOTS; r++) begin
			push_data.values[r] = rep_val[r];
			push_data.counts[r] = rep_cnt[r];
		end
	end

	assign push_valid = accept && in_word.end_of_set;

endmodule

@@ design/hhcv_fifo.sv @@
module hhcv_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  hhcv_pkg::snap_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output hhcv_pkg::snap_t pop_data
);

	hhcv_pkg::snap_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] fill_q;
	logic do_push, do_pop;

	assign push_ready = fill_q != 2'd2;
	assign pop_valid = fill_q != 2'd0;
	assign pop_data = mem_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			fill_q <= fill_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

@@ design/hhcv_back.sv @@
module hhcv_back (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  hhcv_pkg::snap_t pop_data,
	output logic out_valid,
	input  logic out_ready,
	output hhcv_pkg::out_word_t out_word
);

	hhcv_pkg::snap_t snap_q;
	logic busy_q;
	logic [hhcv_pkg::IDX_W-1:0] idx_q;
	logic last;
	logic load;

	assign last = idx_q == snap_q.used - hhcv_pkg::IDX_W'(1);
	assign load = !busy_q || (out_ready && last);
	assign pop_ready = load;

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			snap_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			busy_q <= pop_valid;
			idx_q <= '0;
		end else if (out_ready) begin
			idx_q <= idx_q + hhcv_pkg::IDX_W'(1);
		end
	end

	assign out_valid = busy_q;
	assign out_word.slot_index = idx_q;
	assign out_word.candidate_value = snap_q.values[idx_q];
	assign out_word.candidate_count = snap_q.counts[idx_q];
	assign out_word.final_result = last;

	a_used_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> snap_q.used != '0)
		else $error("snapshot reports no slots");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < snap_q.used)
		else $error("slot index beyond the slots in use");

	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_word.final_result) |=>
		(out_valid && out_word.slot_index == $past(idx_q) + hhcv_pkg::IDX_W'(1)))
		else $error("slot reports out of order");

endmodule

@@ design/heavy_hitter_candidate_vote_core.sv @@
// Candidate vote core: streams signed 32-bit words and tracks up to three
// candidate slots, each a value with a saturating vote count.
// Input channel in_valid/in_ready/in_word carries one value and an end_of_set
// flag. Without end_of_set a word only updates the slots and gives no result.
// With end_of_set the word is applied, the updated slots are captured, and
// the slots return to their reset contents for the next set.
// Output channel out_valid/out_ready/out_word then reports one word per
// active slot in slot order, the last one flagged by final_result.
// cfg_wen/cfg_wdata write the active slot count; write it only while idle.
// Throughput: one input word per cycle while the queue has room. A set's
// first report comes once its snapshot has moved through the queue into the
// report stage, then one per cycle while out_ready is high. The front stage
// updates the slots; a two-deep snapshot queue lets it keep taking words
// while the report stage drains a set, and it stalls only when two captured
// sets are still waiting behind out_ready. Reset clears the slots, the queue
// and the report stage, and sets the active slot count to three.
module heavy_hitter_candidate_vote_core #(
	parameter int SLOTS = 3,
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic [hhcv_pkg::IDX_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  hhcv_pkg::in_word_t in_word,
	output logic out_valid,
	input  logic out_ready,
	output hhcv_pkg::out_word_t out_word
);

	logic push_valid, push_ready, pop_valid, pop_ready;
	hhcv_pkg::snap_t push_data, pop_data;

	hhcv_front #(
		.SLOTS(SLOTS),
		.VALUE_BITS(VALUE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	hhcv_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	hhcv_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

endmodule
